// ===== design/rsk_pkg.sv =====
// Shared types and constants for the record sorter.
// Used by rsk_cell and record_sorter_by_key_core; depends on nothing else.
`default_nettype none

package rsk_pkg;

    typedef struct packed {
        logic [31:0] id;
        logic [31:0] price;
        logic [15:0] rating;
    } rec_t;

    // Controls broadcast to every cell of the chain.
    typedef struct packed {
        logic drain;
        logic sort_key;
        logic descending;
    } cell_ctrl_t;

    localparam logic REG_SORT_KEY   = 1'b0;
    localparam logic REG_DESCENDING = 1'b1;

    localparam logic KEY_PRICE  = 1'b0;
    localparam logic KEY_RATING = 1'b1;

endpackage

`default_nettype wire

// ===== design/rsk_cell.sv =====
// One cell of the insertion-sort chain: holds a record and passes the loser
// of each compare to its right neighbor. Depends on rsk_pkg.
`default_nettype none

module rsk_cell
(
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire rsk_pkg::cell_ctrl_t  ctrl,
    input  wire logic                 in_vld,
    input  wire logic                 in_old,
    input  wire rsk_pkg::rec_t        in_rec,
    input  wire logic                 nbr_vld,
    input  wire rsk_pkg::rec_t        nbr_rec,
    output logic                      hold_vld,
    output rsk_pkg::rec_t             hold_rec,
    output logic                      pass_vld,
    output logic                      pass_old,
    output rsk_pkg::rec_t             pass_rec
);

    logic          hold_vld_reg, hold_vld_next;
    rsk_pkg::rec_t hold_rec_reg, hold_rec_next;
    logic          pass_vld_reg, pass_vld_next;
    logic          pass_old_reg, pass_old_next;
    rsk_pkg::rec_t pass_rec_reg, pass_rec_next;
    logic [31:0]   key_in;
    logic [31:0]   key_hold;
    logic          in_first;

    always_comb
    begin
        key_in   = (ctrl.sort_key == rsk_pkg::KEY_RATING) ? {16'b0, in_rec.rating}
                                                          : in_rec.price;
        key_hold = (ctrl.sort_key == rsk_pkg::KEY_RATING) ? {16'b0, hold_rec_reg.rating}
                                                          : hold_rec_reg.price;
        // A fresh request only moves ahead on a strictly better key. A record
        // pushed out of its cell arrived before any equal-keyed record it
        // meets further down, so it wins ties. Equal keys keep arrival order.
        if (in_old)
        begin
            in_first = ctrl.descending ? (key_in >= key_hold) : (key_in <= key_hold);
        end
        else
        begin
            in_first = ctrl.descending ? (key_in > key_hold) : (key_in < key_hold);
        end
    end

    always_comb
    begin
        hold_vld_next = hold_vld_reg;
        hold_rec_next = hold_rec_reg;
        pass_vld_next = 1'b0;
        pass_old_next = in_old;
        pass_rec_next = in_rec;
        if (ctrl.drain)
        begin
            hold_vld_next = nbr_vld;
            hold_rec_next = nbr_rec;
        end
        else if (in_vld)
        begin
            if (!hold_vld_reg)
            begin
                hold_vld_next = 1'b1;
                hold_rec_next = in_rec;
            end
            else if (in_first)
            begin
                hold_rec_next = in_rec;
                pass_vld_next = 1'b1;
                pass_old_next = 1'b1;
                pass_rec_next = hold_rec_reg;
            end
            else
            begin
                pass_vld_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            hold_vld_reg <= 1'b0;
            pass_vld_reg <= 1'b0;
            pass_old_reg <= 1'b0;
        end
        else
        begin
            hold_vld_reg <= hold_vld_next;
            pass_vld_reg <= pass_vld_next;
            pass_old_reg <= pass_old_next;
        end
    end

    always_ff @(posedge clk)
    begin
        hold_rec_reg <= hold_rec_next;
        pass_rec_reg <= pass_rec_next;
    end

    assign hold_vld = hold_vld_reg;
    assign hold_rec = hold_rec_reg;
    assign pass_vld = pass_vld_reg;
    assign pass_old = pass_old_reg;
    assign pass_rec = pass_rec_reg;

endmodule

`default_nettype wire

// ===== design/record_sorter_by_key_core.sv =====
// Top level of the record sorter: APB registers, load/settle/drain control
// and the chain of rsk_cell instances. Depends on rsk_pkg and rsk_cell.
`default_nettype none

// Records are taken one per cycle while busy is low; each new request enters
// the cell chain and ripples one cell per cycle to its sorted place. A request
// with last_record set starts the drain: the block raises busy, waits in
// ST_SETTLE for the chain to settle, then shifts the chain out one result per
// cycle, with out_valid high on each. The receiver cannot stall: every result
// is on the ports for exactly one cycle.
module record_sorter_by_key_core
#(
    parameter int MAX_RECORDS = 32
)
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        psel,
    input  wire logic        penable,
    input  wire logic        pwrite,
    input  wire logic [2:0]  paddr,
    input  wire logic [31:0] pwdata,
    output logic      [31:0] prdata,
    output logic             pready,
    input  wire logic        start,
    output logic             busy,
    input  wire logic [31:0] record_id,
    input  wire logic [31:0] price_cents,
    input  wire logic [15:0] rating_tenths,
    input  wire logic        last_record,
    output logic             out_valid,
    output logic      [31:0] out_id,
    output logic      [31:0] out_price,
    output logic      [15:0] out_rating,
    output logic             out_last,
    output logic             dropped_some
);

    localparam int FW = $clog2(MAX_RECORDS + 1);
    localparam int CW = $clog2(MAX_RECORDS + 2);
    localparam logic [CW-1:0] SETTLE_LAST = CW'(MAX_RECORDS);
    localparam logic [FW-1:0] FILL_MAX    = FW'(MAX_RECORDS);

    typedef enum logic [2:0] {
        ST_IDLE   = 3'b001,
        ST_SETTLE = 3'b010,
        ST_DRAIN  = 3'b100
    } state_t;

    state_t          state_reg, state_next;
    logic [FW-1:0]   fill_reg, fill_next;
    logic            ovf_reg, ovf_next;
    logic [CW-1:0]   cnt_reg, cnt_next;
    logic            ins_vld_reg, ins_vld_next;
    rsk_pkg::rec_t   ins_rec_reg;
    logic            sort_key_reg, descending_reg;
    logic            ov_reg, ov_next;
    rsk_pkg::rec_t   orec_reg;
    logic            olast_reg, olast_next;
    logic            odrop_reg, odrop_next;
    logic            accept;
    logic            cfg_wr;
    logic            drain_last;
    rsk_pkg::cell_ctrl_t cctrl;

    logic            chain_vld  [MAX_RECORDS+1];
    logic            chain_old  [MAX_RECORDS+1];
    rsk_pkg::rec_t   chain_rec  [MAX_RECORDS+1];
    logic            hold_vld   [MAX_RECORDS+1];
    rsk_pkg::rec_t   hold_rec   [MAX_RECORDS+1];

    // Configuration registers.
    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite && pready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sort_key_reg   <= rsk_pkg::KEY_PRICE;
            descending_reg <= 1'b1;
        end
        else if (cfg_wr)
        begin
            case (paddr[2])
                rsk_pkg::REG_SORT_KEY:   sort_key_reg   <= pwdata[0];
                rsk_pkg::REG_DESCENDING: descending_reg <= pwdata[0];
                default: ;
            endcase
        end
    end

    always_comb
    begin
        case (paddr[2])
            rsk_pkg::REG_SORT_KEY:   prdata = {31'b0, sort_key_reg};
            rsk_pkg::REG_DESCENDING: prdata = {31'b0, descending_reg};
            default:                 prdata = 32'b0;
        endcase
    end

    // Control.
    assign busy       = (state_reg != ST_IDLE);
    assign accept     = start && !busy;
    assign drain_last = (cnt_reg == CW'(fill_reg - FW'(1)));

    always_comb
    begin
        state_next   = state_reg;
        fill_next    = fill_reg;
        ovf_next     = ovf_reg;
        cnt_next     = cnt_reg;
        ins_vld_next = 1'b0;
        ov_next      = 1'b0;
        olast_next   = 1'b0;
        odrop_next   = 1'b0;
        case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    if (fill_reg != FILL_MAX)
                    begin
                        ins_vld_next = 1'b1;
                        fill_next    = fill_reg + FW'(1);
                    end
                    else
                    begin
                        ovf_next = 1'b1;
                    end
                    if (last_record)
                    begin
                        state_next = ST_SETTLE;
                        cnt_next   = '0;
                    end
                end
            end
            ST_SETTLE:
            begin
                if (cnt_reg == SETTLE_LAST)
                begin
                    state_next = ST_DRAIN;
                    cnt_next   = '0;
                end
                else
                begin
                    cnt_next = cnt_reg + CW'(1);
                end
            end
            ST_DRAIN:
            begin
                ov_next    = 1'b1;
                olast_next = drain_last;
                odrop_next = drain_last && ovf_reg;
                cnt_next   = cnt_reg + CW'(1);
                if (drain_last)
                begin
                    state_next = ST_IDLE;
                    fill_next  = '0;
                    ovf_next   = 1'b0;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= ST_IDLE;
            fill_reg    <= '0;
            ovf_reg     <= 1'b0;
            cnt_reg     <= '0;
            ins_vld_reg <= 1'b0;
            ov_reg      <= 1'b0;
            olast_reg   <= 1'b0;
            odrop_reg   <= 1'b0;
        end
        else
        begin
            state_reg   <= state_next;
            fill_reg    <= fill_next;
            ovf_reg     <= ovf_next;
            cnt_reg     <= cnt_next;
            ins_vld_reg <= ins_vld_next;
            ov_reg      <= ov_next;
            olast_reg   <= olast_next;
            odrop_reg   <= odrop_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            ins_rec_reg <= '{id: record_id, price: price_cents, rating: rating_tenths};
        end
        if (state_reg == ST_DRAIN)
        begin
            orec_reg <= hold_rec[0];
        end
    end

    // Cell chain. Cell 0 holds the record that leaves first.
    assign cctrl.drain      = (state_reg == ST_DRAIN);
    assign cctrl.sort_key   = sort_key_reg;
    assign cctrl.descending = descending_reg;

    assign chain_vld[0]           = ins_vld_reg;
    assign chain_old[0]           = 1'b0;
    assign chain_rec[0]           = ins_rec_reg;
    assign hold_vld[MAX_RECORDS]  = 1'b0;
    assign hold_rec[MAX_RECORDS]  = '0;

    for (genvar gi = 0; gi < MAX_RECORDS; gi++)
    begin : g_cell
        rsk_cell u_cell
        (
            .clk      (clk),
            .rst_n    (rst_n),
            .ctrl     (cctrl),
            .in_vld   (chain_vld[gi]),
            .in_old   (chain_old[gi]),
            .in_rec   (chain_rec[gi]),
            .nbr_vld  (hold_vld[gi+1]),
            .nbr_rec  (hold_rec[gi+1]),
            .hold_vld (hold_vld[gi]),
            .hold_rec (hold_rec[gi]),
            .pass_vld (chain_vld[gi+1]),
            .pass_old (chain_old[gi+1]),
            .pass_rec (chain_rec[gi+1])
        );
    end

    assign out_valid    = ov_reg;
    assign out_id       = orec_reg.id;
    assign out_price    = orec_reg.price;
    assign out_rating   = orec_reg.rating;
    assign out_last     = olast_reg;
    assign dropped_some = odrop_reg;

`ifndef ASSERT_OFF
    // The fill limit must keep records from falling off the end of the chain.
    a_no_spill: assert property (@(posedge clk) disable iff (!rst_n)
        !chain_vld[MAX_RECORDS])
        else $error("record pushed out of the last cell");

    a_fill_bound: assert property (@(posedge clk) disable iff (!rst_n)
        fill_reg <= FILL_MAX)
        else $error("fill level above capacity");

    a_out_from_drain: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> $past(state_reg == ST_DRAIN))
        else $error("result outside drain");

    a_last_ends_run: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && out_last) |-> (state_reg == ST_IDLE && fill_reg == '0 && !ovf_reg))
        else $error("run did not end with the final result");

    a_drop_on_last: assert property (@(posedge clk) disable iff (!rst_n)
        dropped_some |-> (out_valid && out_last))
        else $error("drop flag away from the final result");

    a_drain_cell0: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_DRAIN) |-> hold_vld[0])
        else $error("drain reads an empty head cell");
`endif

endmodule

`default_nettype wire
